@@ src/mpp_pkg.sv @@
// Shared widths, codes and helpers of the mecanum position move planner.
`timescale 1ns / 1ps

package mpp_pkg;

   localparam int TR_W       = 18;
   localparam int CS_W       = 19;
   localparam int SX_W       = 24;
   localparam int DEG_W      = 27;
   localparam int SLOT_W     = 8;
   localparam int STAT_W     = 2;
   localparam int SPD_W      = 20;
   localparam int DIST_W     = 26;
   localparam int DUR_W      = 24;
   localparam int REJ_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 19;

   localparam int WORK_W     = 27;
   localparam int RMAG_W     = 24;
   localparam int ROT_SHIFT  = 40;

   localparam int MUL_A_W    = 38;
   localparam int MUL_B_W    = 27;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

   localparam int DIV_D_W    = 27;
   localparam int DIV_Q_W    = 24;
   localparam int DIV_C_W    = 5;
   localparam int WHEEL_Q_W  = 19;
   localparam int DUR_Q_W    = 24;

   localparam int NUM_WHEELS = 4;

   localparam logic [SLOT_W-1:0] FRAMES_PER_MOVE = SLOT_W'(5);
   localparam logic [CS_W-1:0]   DEG_TO_RAD_Q24  = CS_W'(292818);
   localparam logic [CS_W-1:0]   CRUISE_RESET    = CS_W'(13107);
   localparam logic [DUR_W-1:0]  DUR_PAD         = DUR_W'(100);
   localparam logic [DUR_W-1:0]  DUR_MAX         = '1;

   localparam logic [STAT_W-1:0] STATUS_NOMOVE   = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ISSUED   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_REJECTED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TURN_RADIUS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRUISE_SPEED = 1'd1;

   localparam logic [1:0] WHEEL_FL = 2'd0;
   localparam logic [1:0] WHEEL_FR = 2'd1;
   localparam logic [1:0] WHEEL_RL = 2'd2;
   localparam logic [1:0] WHEEL_RR = 2'd3;

   function automatic logic [DIST_W-1:0] abs_dist(input logic [DIST_W-1:0] v);
      logic [DIST_W-1:0] r;
      r = v;
      if (v[DIST_W-1]) r = ~v + 1'b1;
      return r;
   endfunction

endpackage

@@ src/mpp_mul.sv @@
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module mpp_mul import mpp_pkg::*; #(
   parameter int A_W = MUL_A_W,
   parameter int B_W = MUL_B_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [A_W-1:0]       a,
   input  logic [B_W-1:0]       b,
   output logic                 done,
   output logic [A_W+B_W-1:0]   p
);

   localparam int CNT_W = $clog2(B_W);

   logic [A_W-1:0]   a_ff, a_in;
   logic [A_W-1:0]   hi_ff, hi_in;
   logic [B_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [A_W:0]     sum;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         {hi_in, lo_in} = {sum, lo_ff[B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;
   assign p    = {hi_ff, lo_ff};

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier restarted while busy");

endmodule

@@ src/mpp_div.sv @@
// Restoring divider, one quotient bit per cycle, remainder seeded below the divisor.
`timescale 1ns / 1ps

module mpp_div import mpp_pkg::*; #(
   parameter int D_W = DIV_D_W,
   parameter int Q_W = DIV_Q_W,
   parameter int C_W = DIV_C_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [D_W-1:0] rem0,
   input  logic [Q_W-1:0] low,
   input  logic [D_W-1:0] den,
   input  logic [C_W-1:0] steps,
   output logic           done,
   output logic [Q_W-1:0] quo
);

   logic [D_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0] low_ff, low_in;
   logic [D_W-1:0] den_ff, den_in;
   logic [C_W-1:0] steps_ff, steps_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [D_W:0]   shifted;
   logic [D_W:0]   diff;
   logic           fits;

   assign shifted = {rem_ff, low_ff[Q_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = !diff[D_W];

   always_comb begin
      rem_in   = rem_ff;
      low_in   = low_ff;
      den_in   = den_ff;
      steps_in = steps_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = rem0;
         low_in   = low;
         den_in   = den;
         steps_in = steps;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[D_W-1:0] : shifted[D_W-1:0];
         low_in = {low_ff[Q_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == steps_ff - 1'b1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      den_ff   <= den_in;
      steps_ff <= steps_in;
   end

   assign done = done_ff;
   assign quo  = low_ff;

   a_seed_below_den: assert property (@(posedge clock) disable iff (reset)
      start |-> (rem0 < den) && !busy_ff)
      else $error("divider seeded with remainder not below divisor");

endmodule

@@ src/mecanum_position_move_planner.sv @@
// Top level: mecanum move planner, sequencer around a serial multiplier and divider.
// Sequence: no-move and rejected items finish after classification, while an issued move
//   goes on through six multiplies and up to five divides (one per wheel, one for duration).
// Throughput: one item at a time; the next item is accepted once the result has been
//   moved to the output register, even while that result still waits.
// Reset (synchronous): turn_radius 0, cruise_speed 13107, reject count 0, no result pending.
`timescale 1ns / 1ps

module mecanum_position_move_planner import mpp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SX_W-1:0]       req_shift_x,
   input  logic signed [SX_W-1:0]       req_shift_y,
   input  logic signed [DEG_W-1:0]      req_turn_degrees,
   input  logic [SLOT_W-1:0]            req_free_slots,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [STAT_W-1:0]            rsp_status,
   output logic signed [SPD_W-1:0]      rsp_front_left_speed,
   output logic signed [SPD_W-1:0]      rsp_front_right_speed,
   output logic signed [SPD_W-1:0]      rsp_rear_left_speed,
   output logic signed [SPD_W-1:0]      rsp_rear_right_speed,
   output logic signed [DIST_W-1:0]     rsp_front_left_distance,
   output logic signed [DIST_W-1:0]     rsp_front_right_distance,
   output logic signed [DIST_W-1:0]     rsp_rear_left_distance,
   output logic signed [DIST_W-1:0]     rsp_rear_right_distance,
   output logic [DUR_W-1:0]             rsp_move_ms,
   output logic [REJ_W-1:0]             rsp_reject_total,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wr_data
);

   localparam int NW_W = DIST_W + 1 + CS_W;
   localparam int TH_W = DIST_W + 10;
   localparam int NT_W = DIST_W + 11;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_MUL_K  = 11'b000_0000_0010,
      ST_MUL_P  = 11'b000_0000_0100,
      ST_ROT    = 11'b000_0000_1000,
      ST_MAX    = 11'b000_0001_0000,
      ST_CLASS  = 11'b000_0010_0000,
      ST_MUL_W  = 11'b000_0100_0000,
      ST_DIV_W  = 11'b000_1000_0000,
      ST_TSET   = 11'b001_0000_0000,
      ST_DIV_T  = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [TR_W-1:0]         radius_ff, radius_in;
   logic [CS_W-1:0]         cruise_ff, cruise_in;
   logic [REJ_W-1:0]        rej_ff, rej_in;
   logic                    mul_start_ff, mul_start_in;
   logic                    div_start_ff, div_start_in;

   logic signed [SX_W-1:0]  x_ff, x_in;
   logic signed [SX_W-1:0]  y_ff, y_in;
   logic                    deg_neg_ff, deg_neg_in;
   logic [DEG_W-1:0]        absdeg_ff, absdeg_in;
   logic [SLOT_W-1:0]       slots_ff, slots_in;
   logic [CS_W-1:0]         spd_ff, spd_in;
   logic [DIST_W-1:0]       d_ff [NUM_WHEELS];
   logic [DIST_W-1:0]       d_in [NUM_WHEELS];
   logic [DIST_W-1:0]       m_ff, m_in;
   logic [1:0]              idx_ff, idx_in;
   logic [SPD_W-1:0]        speed_ff [NUM_WHEELS];
   logic [SPD_W-1:0]        speed_in [NUM_WHEELS];
   logic [DUR_W-1:0]        dur_ff, dur_in;
   logic [STAT_W-1:0]       status_ff, status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]       o_status_ff, o_status_in;
   logic [SPD_W-1:0]        o_speed_ff [NUM_WHEELS];
   logic [SPD_W-1:0]        o_speed_in [NUM_WHEELS];
   logic [DIST_W-1:0]       o_dist_ff [NUM_WHEELS];
   logic [DIST_W-1:0]       o_dist_in [NUM_WHEELS];
   logic [DUR_W-1:0]        o_dur_ff, o_dur_in;
   logic [REJ_W-1:0]        o_rej_ff, o_rej_in;

   logic                    mul_done;
   logic [MUL_P_W-1:0]      mul_p;
   logic [MUL_A_W-1:0]      mul_a;
   logic [MUL_B_W-1:0]      mul_b;
   logic                    div_done;
   logic [DIV_Q_W-1:0]      div_quo;
   logic [DIV_D_W-1:0]      div_rem0;
   logic [DIV_Q_W-1:0]      div_low;
   logic [DIV_D_W-1:0]      div_den;
   logic [DIV_C_W-1:0]      div_steps;

   logic [DEG_W-1:0]        req_deg_u;
   logic [DEG_W-1:0]        req_absdeg;
   logic [RMAG_W-1:0]       rmag;
   logic signed [WORK_W-1:0] srot_mag, srot, xw, yw;
   logic signed [WORK_W-1:0] dfl, dfr, drl, drr;
   logic [DIST_W-1:0]       a0, a1, a2, a3, m01, m23, m_max;
   logic [TH_W-1:0]         thousand_m;
   logic                    no_move;
   logic [NT_W-1:0]         nt;
   logic                    dur_sat;
   logic [NW_W-1:0]         nw;
   logic [DIST_W-1:0]       cur_d;
   logic [SPD_W-1:0]        q_mag;
   logic [DUR_W:0]          dur_sum;

   assign req_deg_u  = req_turn_degrees;
   assign req_absdeg = req_deg_u[DEG_W-1] ? ~req_deg_u + 1'b1 : req_deg_u;

   assign rmag     = RMAG_W'(mul_p[ROT_SHIFT+RMAG_W-1:ROT_SHIFT] +
                             RMAG_W'(mul_p[ROT_SHIFT-1]));
   assign srot_mag = $signed(WORK_W'(rmag));
   assign srot     = deg_neg_ff ? -srot_mag : srot_mag;
   assign xw       = WORK_W'(x_ff);
   assign yw       = WORK_W'(y_ff);
   assign dfl      = yw - xw - srot;
   assign dfr      = yw + xw + srot;
   assign drl      = yw + xw - srot;
   assign drr      = yw - xw + srot;

   assign a0    = abs_dist(d_ff[WHEEL_FL]);
   assign a1    = abs_dist(d_ff[WHEEL_FR]);
   assign a2    = abs_dist(d_ff[WHEEL_RL]);
   assign a3    = abs_dist(d_ff[WHEEL_RR]);
   assign m01   = (a0 > a1) ? a0 : a1;
   assign m23   = (a2 > a3) ? a2 : a3;
   assign m_max = (m01 > m23) ? m01 : m23;

   // 1000*m and 2000*m + speed as shift-subtract
   assign thousand_m = {m_ff, 10'b0} - TH_W'({m_ff, 4'b0}) - TH_W'({m_ff, 3'b0});
   assign no_move    = thousand_m < TH_W'(spd_ff);
   assign nt         = {m_ff, 11'b0} - NT_W'({m_ff, 5'b0}) - NT_W'({m_ff, 4'b0})
                       + NT_W'(spd_ff);
   assign dur_sat    = DIV_D_W'(nt[NT_W-1:DUR_Q_W]) >= DIV_D_W'({spd_ff, 1'b0});

   assign cur_d   = d_ff[idx_ff];
   assign nw      = NW_W'(mul_p[NW_W-1:0]) + NW_W'(m_ff);
   assign q_mag   = SPD_W'(div_quo[WHEEL_Q_W-1:0]);
   assign dur_sum = {1'b0, div_quo} + {1'b0, DUR_PAD};

   always_comb begin
      unique case (state_ff)
         ST_MUL_K: begin
            mul_a = MUL_A_W'(DEG_TO_RAD_Q24);
            mul_b = MUL_B_W'(radius_ff);
         end
         ST_MUL_P: begin
            mul_a = mul_p[MUL_A_W-1:0];
            mul_b = MUL_B_W'(absdeg_ff);
         end
         default: begin
            mul_a = MUL_A_W'({abs_dist(cur_d), 1'b0});
            mul_b = MUL_B_W'(spd_ff);
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_DIV_T: begin
            div_rem0  = DIV_D_W'(nt[NT_W-1:DUR_Q_W]);
            div_low   = nt[DUR_Q_W-1:0];
            div_den   = DIV_D_W'({spd_ff, 1'b0});
            div_steps = DIV_C_W'(DUR_Q_W);
         end
         default: begin
            div_rem0  = nw[NW_W-1:WHEEL_Q_W];
            div_low   = {nw[WHEEL_Q_W-1:0], (DIV_Q_W - WHEEL_Q_W)'(0)};
            div_den   = DIV_D_W'({m_ff, 1'b0});
            div_steps = DIV_C_W'(WHEEL_Q_W);
         end
      endcase
   end

   mpp_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start_ff),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   mpp_div #(
      .D_W (DIV_D_W),
      .Q_W (DIV_Q_W),
      .C_W (DIV_C_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .rem0  (div_rem0),
      .low   (div_low),
      .den   (div_den),
      .steps (div_steps),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      radius_in    = radius_ff;
      cruise_in    = cruise_ff;
      rej_in       = rej_ff;
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      x_in         = x_ff;
      y_in         = y_ff;
      deg_neg_in   = deg_neg_ff;
      absdeg_in    = absdeg_ff;
      slots_in     = slots_ff;
      spd_in       = spd_ff;
      d_in         = d_ff;
      m_in         = m_ff;
      idx_in       = idx_ff;
      speed_in     = speed_ff;
      dur_in       = dur_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      o_status_in  = o_status_ff;
      o_speed_in   = o_speed_ff;
      o_dist_in    = o_dist_ff;
      o_dur_in     = o_dur_ff;
      o_rej_in     = o_rej_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_TURN_RADIUS:  radius_in = csr_wr_data[TR_W-1:0];
            REG_CRUISE_SPEED: cruise_in = csr_wr_data[CS_W-1:0];
         endcase
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in         = req_shift_x;
               y_in         = req_shift_y;
               deg_neg_in   = req_turn_degrees[DEG_W-1];
               absdeg_in    = req_absdeg;
               slots_in     = req_free_slots;
               spd_in       = (cruise_ff == '0) ? CS_W'(1) : cruise_ff;
               state_in     = ST_MUL_K;
               mul_start_in = 1'b1;
            end
         end
         ST_MUL_K: begin
            if (mul_done) begin
               state_in     = ST_MUL_P;
               mul_start_in = 1'b1;
            end
         end
         ST_MUL_P: begin
            if (mul_done) state_in = ST_ROT;
         end
         ST_ROT: begin
            d_in[WHEEL_FL] = dfl[DIST_W-1:0];
            d_in[WHEEL_FR] = dfr[DIST_W-1:0];
            d_in[WHEEL_RL] = drl[DIST_W-1:0];
            d_in[WHEEL_RR] = drr[DIST_W-1:0];
            state_in       = ST_MAX;
         end
         ST_MAX: begin
            m_in     = m_max;
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            for (int i = 0; i < NUM_WHEELS; i++) speed_in[i] = '0;
            dur_in = '0;
            idx_in = WHEEL_FL;
            if (no_move) begin
               status_in = STATUS_NOMOVE;
               for (int i = 0; i < NUM_WHEELS; i++) d_in[i] = '0;
               state_in  = ST_FINISH;
            end else if (slots_ff < FRAMES_PER_MOVE) begin
               status_in = STATUS_REJECTED;
               if (rej_ff != '1) rej_in = rej_ff + 1'b1;
               state_in  = ST_FINISH;
            end else begin
               status_in    = STATUS_ISSUED;
               state_in     = ST_MUL_W;
               mul_start_in = 1'b1;
            end
         end
         ST_MUL_W: begin
            if (mul_done) begin
               state_in     = ST_DIV_W;
               div_start_in = 1'b1;
            end
         end
         ST_DIV_W: begin
            if (div_done) begin
               speed_in[idx_ff] = cur_d[DIST_W-1] ? -q_mag : q_mag;
               if (idx_ff == WHEEL_RR) begin
                  state_in = ST_TSET;
               end else begin
                  idx_in       = idx_ff + 1'b1;
                  state_in     = ST_MUL_W;
                  mul_start_in = 1'b1;
               end
            end
         end
         ST_TSET: begin
            if (dur_sat) begin
               dur_in   = DUR_MAX;
               state_in = ST_FINISH;
            end else begin
               state_in     = ST_DIV_T;
               div_start_in = 1'b1;
            end
         end
         ST_DIV_T: begin
            if (div_done) begin
               dur_in   = dur_sum[DUR_W] ? DUR_MAX : dur_sum[DUR_W-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               o_status_in  = status_ff;
               o_speed_in   = speed_ff;
               o_dist_in    = d_ff;
               o_dur_in     = dur_ff;
               o_rej_in     = rej_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= '0;
         cruise_ff    <= CRUISE_RESET;
         rej_ff       <= '0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         cruise_ff    <= cruise_in;
         rej_ff       <= rej_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      deg_neg_ff  <= deg_neg_in;
      absdeg_ff   <= absdeg_in;
      slots_ff    <= slots_in;
      spd_ff      <= spd_in;
      d_ff        <= d_in;
      m_ff        <= m_in;
      idx_ff      <= idx_in;
      speed_ff    <= speed_in;
      dur_ff      <= dur_in;
      status_ff   <= status_in;
      o_status_ff <= o_status_in;
      o_speed_ff  <= o_speed_in;
      o_dist_ff   <= o_dist_in;
      o_dur_ff    <= o_dur_in;
      o_rej_ff    <= o_rej_in;
   end

   assign req_ready                = (state_ff == ST_IDLE);
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = o_status_ff;
   assign rsp_front_left_speed     = o_speed_ff[WHEEL_FL];
   assign rsp_front_right_speed    = o_speed_ff[WHEEL_FR];
   assign rsp_rear_left_speed      = o_speed_ff[WHEEL_RL];
   assign rsp_rear_right_speed     = o_speed_ff[WHEEL_RR];
   assign rsp_front_left_distance  = o_dist_ff[WHEEL_FL];
   assign rsp_front_right_distance = o_dist_ff[WHEEL_FR];
   assign rsp_rear_left_distance   = o_dist_ff[WHEEL_RL];
   assign rsp_rear_right_distance  = o_dist_ff[WHEEL_RR];
   assign rsp_move_ms              = o_dur_ff;
   assign rsp_reject_total         = o_rej_ff;

   a_idle_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (o_status_ff != STATUS_ISSUED) |->
         (o_dur_ff == '0) && (o_speed_ff[WHEEL_FL] == '0) &&
         (o_speed_ff[WHEEL_FR] == '0) && (o_speed_ff[WHEEL_RL] == '0) &&
         (o_speed_ff[WHEEL_RR] == '0))
      else $error("speeds or duration set on an item that was not issued");

   a_reject_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLASS) && !no_move && (slots_ff < FRAMES_PER_MOVE) &&
         (rej_ff != '1) |=> rej_ff == $past(rej_ff) + 1'b1)
      else $error("reject count did not advance");

   a_speed_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_W) && div_done |->
         div_quo <= DIV_Q_W'(spd_ff))
      else $error("wheel speed above cruise speed");

endmodule
